// ===== rtl/skf_pkg.sv =====
package skf_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_V,
        S_PRED,
        S_DEN,
        S_MUL_A,
        S_MUL_B,
        S_FIX,
        S_DIV_X,
        S_MUL_PR,
        S_DIV_P,
        S_DONE
    } t_state;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_VAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR  = 3'd5;

    // reset values in whole units (velocity and time step are one half)
    localparam int RST_MEAS_VAR_UNITS  = 100;
    localparam int RST_MODEL_VAR_UNITS = 3;
    localparam int RST_INIT_EST_UNITS  = 1;
    localparam int RST_INIT_VAR_UNITS  = 3;

    // multiplier digit width, bits of the second operand per cycle
    localparam int MUL_DIGIT = 16;

endpackage

// ===== rtl/skf_meas_if.sv =====
interface skf_meas_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink (input valid, input measurement, output ready);
endinterface

// ===== rtl/skf_est_if.sv =====
interface skf_est_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] estimate;
    logic        [DATA_WIDTH-1:0] estimate_variance;

    modport source (output valid, output estimate, output estimate_variance, input ready);
    modport sink (input valid, input estimate, input estimate_variance, output ready);
endinterface

// ===== rtl/skf_mul.sv =====
module skf_mul import skf_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DATA_WIDTH-1:0]     i_a,
    input  logic [DATA_WIDTH-1:0]     i_b,
    output t_unit_sts                 o_sts,
    output logic [2*DATA_WIDTH-1:0]   o_prod
);
    localparam int W  = DATA_WIDTH;
    localparam int ND = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LW = MUL_DIGIT * ND;
    localparam int PW = W + LW;
    localparam int CW = $clog2(ND + 1);

    logic [W-1:0]           r_a;
    logic [PW-1:0]          r_p;
    logic [CW-1:0]          r_cnt;
    logic                   r_done;
    logic [W+MUL_DIGIT-1:0] w_pp;
    logic [W+MUL_DIGIT-1:0] w_sum;
    logic [PW-1:0]          n_p;

    // one digit of b per cycle, partial sum shifts right out of the low half
    always_comb begin
        w_pp  = (W+MUL_DIGIT)'(r_a) * (W+MUL_DIGIT)'(r_p[MUL_DIGIT-1:0]);
        w_sum = (W+MUL_DIGIT)'(r_p[PW-1 -: W]) + w_pp;
        n_p   = (PW'(w_sum) << (LW - MUL_DIGIT)) | PW'(r_p[LW-1:0] >> MUL_DIGIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(ND);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= PW'(i_b);
        end else if (r_cnt != '0) begin
            r_p <= n_p;
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_prod     = r_p[2*W-1:0];

endmodule

// ===== rtl/skf_div.sv =====
module skf_div import skf_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*DATA_WIDTH+1:0]   i_num,
    input  logic [DATA_WIDTH:0]       i_den,
    output t_unit_sts                 o_sts,
    output logic [DATA_WIDTH-1:0]     o_quot
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_q;
    logic [W:0]    r_den;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [W+1:0]  w_trial;
    logic [W+1:0]  w_diff;
    logic          w_ge;

    // restoring division, one quotient bit per cycle; quotient known to fit W bits
    always_comb begin
        w_trial = {r_rem, r_q[W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[2*W:W];
            r_q   <= i_num[W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[W:0] : w_trial[W:0];
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// channel   dir  payload                          beat taken when
// i_meas    in   measurement (signed)             i_meas.valid & i_meas.ready
// o_est     out  estimate, estimate_variance      o_est.valid & o_est.ready
// cfg       in   i_cfg_index, i_cfg_data          i_cfg_we
//
// one sample at a time: from the accepted beat to the loaded result, most of the
// time is the bit-serial divider run twice; the first sample skips predict
// i_meas.ready is high only while the sequencer idles; a result waiting in the
// output register does not block the next sample, only the final load
// synchronous active-low reset restores the registers and forgets the estimate
module scalar_kalman_filter import skf_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    skf_meas_if.sink              i_meas,
    skf_est_if.source             o_est
);
    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;

    localparam logic [W-1:0] RST_MEAS_VAR  = W'(64'(RST_MEAS_VAR_UNITS) << F);
    localparam logic [W-1:0] RST_MODEL_VAR = W'(64'(RST_MODEL_VAR_UNITS) << F);
    localparam logic [W-1:0] RST_HALF      = W'(64'd1 << (F - 1));
    localparam logic [W-1:0] RST_INIT_EST  = W'(64'(RST_INIT_EST_UNITS) << F);
    localparam logic [W-1:0] RST_INIT_VAR  = W'(64'(RST_INIT_VAR_UNITS) << F);
    // rounding constant for the velocity times time step product
    localparam logic [2*W-1:0] PRED_RND    = (2*W)'(1) << (F - 1);
    localparam logic [W:0]     DELTA_CAP   = (W+1)'(1) << W;

    // configuration
    logic [W-1:0] r_meas_var;
    logic [W-1:0] r_model_var;
    logic [W-1:0] r_velocity;
    logic [W-1:0] r_time_step;
    logic [W-1:0] r_init_est;
    logic [W-1:0] r_init_var;

    // filter state and working registers
    t_state       r_state;
    t_state       n_state;
    logic         r_wait;
    logic         r_started;
    logic [W-1:0] r_x;        // estimate, two's complement
    logic [W-1:0] r_p;        // variance
    logic [W-1:0] r_z;        // current measurement
    logic [W:0]   r_d;        // p + r
    logic [2*W-1:0] r_a;      // first product, or rounded predict step
    logic [2*W:0] r_n;        // numerator before rounding
    logic         r_neg;      // sign of the new estimate

    // output register
    logic         r_out_valid;
    logic [W-1:0] r_out_est;
    logic [W-1:0] r_out_var;

    // control
    logic in_acc;
    logic is_mul;
    logic is_div;
    logic mul_start;
    logic div_start;
    logic step_done;
    logic out_load;
    logic same_sign;

    // datapath
    logic [W-1:0]     v_mag;
    logic [W-1:0]     z_mag;
    logic [W-1:0]     x_mag;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     mul_b;
    logic [2*W-1:0]   mul_prod;
    t_unit_sts        mul_sts;
    logic [2*W+1:0]   div_num;
    logic [W-1:0]     div_quot;
    t_unit_sts        div_sts;
    logic             delta_big;
    logic [W:0]       delta;
    logic [W+1:0]     x_ext;
    logic [W+1:0]     pred_sum;
    logic [W-1:0]     pred_x;
    logic [W:0]       var_sum;
    logic [W:0]       den_sum;

    always_comb begin
        v_mag = r_velocity[W-1] ? ('0 - r_velocity) : r_velocity;
        z_mag = r_z[W-1] ? ('0 - r_z) : r_z;
        x_mag = r_x[W-1] ? ('0 - r_x) : r_x;
        same_sign = (r_z[W-1] == r_x[W-1]);
    end

    // operands of the shared multiplier follow the sequencer
    always_comb begin
        case (r_state)
            S_MUL_V: begin
                mul_a = v_mag;
                mul_b = r_time_step;
            end
            S_MUL_A: begin
                mul_a = r_p;
                mul_b = z_mag;
            end
            S_MUL_B: begin
                mul_a = r_meas_var;
                mul_b = x_mag;
            end
            default: begin
                mul_a = r_p;
                mul_b = r_meas_var;
            end
        endcase
    end

    // predict: clamp the step at 2^W, add or subtract, saturate to signed range; also P + Q and P + R
    always_comb begin
        delta_big = (|r_a[2*W-1:W+1]) || (r_a[W] && (|r_a[W-1:0]));
        delta     = delta_big ? DELTA_CAP : r_a[W:0];
        x_ext     = {r_x[W-1], r_x[W-1], r_x};
        pred_sum  = r_velocity[W-1] ? (x_ext - {1'b0, delta}) : (x_ext + {1'b0, delta});
        if (pred_sum[W+1] && (pred_sum[W:W-1] != 2'b11)) begin
            pred_x = {1'b1, {(W-1){1'b0}}};
        end else if (!pred_sum[W+1] && (pred_sum[W:W-1] != 2'b00)) begin
            pred_x = {1'b0, {(W-1){1'b1}}};
        end else begin
            pred_x = pred_sum[W-1:0];
        end
        var_sum = {1'b0, r_p} + {1'b0, r_model_var};
        den_sum = {1'b0, r_p} + {1'b0, r_meas_var};
        // round to nearest: add half the denominator before dividing
        div_num = {1'b0, r_n} + (2*W+2)'(r_d[W:1]);
    end

    skf_mul #(
        .DATA_WIDTH (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    skf_div #(
        .DATA_WIDTH (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_d),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // sequencer outputs
    always_comb begin
        is_mul = (r_state == S_MUL_V) || (r_state == S_MUL_A) ||
                 (r_state == S_MUL_B) || (r_state == S_MUL_PR);
        is_div = (r_state == S_DIV_X) || (r_state == S_DIV_P);
        // a unit is launched in the first cycle of its state, then awaited
        mul_start = is_mul && !r_wait;
        div_start = is_div && !r_wait;
        step_done = r_wait && ((is_mul && mul_sts.done) || (is_div && div_sts.done));
        i_meas.ready = (r_state == S_IDLE);
        in_acc   = i_meas.valid && (r_state == S_IDLE);
        out_load = (r_state == S_DONE) && (!r_out_valid || o_est.ready);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = r_started ? S_MUL_V : S_DEN;
                end
            end
            S_MUL_V: begin
                if (step_done) begin
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                n_state = S_DEN;
            end
            S_DEN: begin
                // zero denominator keeps the estimate, variance goes to zero
                n_state = (den_sum == '0) ? S_DONE : S_MUL_A;
            end
            S_MUL_A: begin
                if (step_done) begin
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B: begin
                if (step_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_DIV_X;
            end
            S_DIV_X: begin
                if (step_done) begin
                    n_state = S_MUL_PR;
                end
            end
            S_MUL_PR: begin
                if (step_done) begin
                    n_state = S_DIV_P;
                end
            end
            S_DIV_P: begin
                if (step_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_meas_var  <= RST_MEAS_VAR;
            r_model_var <= RST_MODEL_VAR;
            r_velocity  <= RST_HALF;
            r_time_step <= RST_HALF;
            r_init_est  <= RST_INIT_EST;
            r_init_var  <= RST_INIT_VAR;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start) begin
                r_wait <= 1'b1;
            end else if (step_done) begin
                r_wait <= 1'b0;
            end
            if (in_acc) begin
                r_started <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_est.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MEAS_VAR:  r_meas_var  <= i_cfg_data;
                    CFG_MODEL_VAR: r_model_var <= i_cfg_data;
                    CFG_VELOCITY:  r_velocity  <= i_cfg_data;
                    CFG_TIME_STEP: r_time_step <= i_cfg_data;
                    CFG_INIT_EST:  r_init_est  <= i_cfg_data;
                    CFG_INIT_VAR:  r_init_var  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // estimate and variance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_p <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // first sample starts from the configured prior
                    if (in_acc && !r_started) begin
                        r_x <= r_init_est;
                        r_p <= r_init_var;
                    end
                end
                S_PRED: begin
                    r_x <= pred_x;
                    r_p <= var_sum[W] ? '1 : var_sum[W-1:0];
                end
                S_DEN: begin
                    if (den_sum == '0) begin
                        r_p <= '0;
                    end
                end
                S_DIV_X: begin
                    if (step_done) begin
                        r_x <= r_neg ? ('0 - div_quot) : div_quot;
                    end
                end
                S_DIV_P: begin
                    if (step_done) begin
                        r_p <= div_quot;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_z <= i_meas.measurement;
                end
            end
            S_MUL_V: begin
                if (step_done) begin
                    r_a <= (mul_prod + PRED_RND) >> F;
                end
            end
            S_DEN: begin
                r_d <= den_sum;
            end
            S_MUL_A: begin
                if (step_done) begin
                    r_a <= mul_prod;
                end
            end
            S_MUL_B: begin
                // p*|z| and r*|x| add when the signs agree, else subtract
                if (step_done) begin
                    r_n <= same_sign ? ({1'b0, r_a} + {1'b0, mul_prod})
                                     : ({1'b0, r_a} - {1'b0, mul_prod});
                end
            end
            S_FIX: begin
                if (!same_sign && r_n[2*W]) begin
                    r_n   <= '0 - r_n;
                    r_neg <= r_x[W-1];
                end else begin
                    r_neg <= r_z[W-1];
                end
            end
            S_MUL_PR: begin
                if (step_done) begin
                    r_n <= {1'b0, mul_prod};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_est <= r_x;
            r_out_var <= r_p;
        end
    end

    assign o_est.valid             = r_out_valid;
    assign o_est.estimate          = r_out_est;
    assign o_est.estimate_variance = r_out_var;

    // the multiplier is never relaunched while it still iterates
    a_mul_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier launched while busy");

    // the divider is never relaunched while it still iterates
    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider launched while busy");

    // a divider result only shows up while a division is awaited
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_wait && ((r_state == S_DIV_X) || (r_state == S_DIV_P))))
        else $error("divider done outside a division state");

    // an accepted sample always starts the sequencer
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sample accepted but sequencer stayed idle");

    // the prior is consumed only by an accepted sample
    a_started_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_started) |-> $past(in_acc))
        else $error("started flag set without a sample");

endmodule

// ===== verif/scalar_kalman_filter_tb.sv =====
`timescale 1ns / 100ps

// testbench for the scalar kalman filter
// a predictor inside the bench tracks estimate and variance in exact wide
// integer arithmetic; every result beat is compared against the oldest
// pending expectation. directed tests hit the first sample, rounding ties,
// predict saturation, variance saturation, a zero denominator and spare
// register indexes, and one long output stall; random phases then sweep
// settings and samples with idle bursts on both channels
module scalar_kalman_filter_tb import skf_pkg::*; ();

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FINAL_SETTLE = 120;

    // register indexes past the end of the list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    localparam logic signed [63:0] EST_MAX = 64'sd2147483647;
    localparam logic signed [63:0] EST_MIN = -64'sd2147483648;
    localparam logic [63:0] VAR_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic signed [DW-1:0] estimate;
        logic        [DW-1:0] variance;
    } t_est_beat;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DW-1:0] i_cfg_data;

    skf_meas_if #(.DATA_WIDTH(DW)) meas_ch ();
    skf_est_if #(.DATA_WIDTH(DW)) est_ch ();

    scalar_kalman_filter #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_meas     (meas_ch),
        .o_est      (est_ch)
    );

    // 12 ns period, starts low
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // bench copy of the filter settings, reset values first
    logic        [DW-1:0] r_meas_var  = RST_MEAS_VAR_UNITS << FB;
    logic        [DW-1:0] r_model_var = RST_MODEL_VAR_UNITS << FB;
    logic signed [DW-1:0] r_velocity  = 1 << (FB - 1);
    logic        [DW-1:0] r_time_step = 1 << (FB - 1);
    logic signed [DW-1:0] r_init_est  = RST_INIT_EST_UNITS << FB;
    logic        [DW-1:0] r_init_var  = RST_INIT_VAR_UNITS << FB;

    // tracked filter state, wide enough to hold unsaturated sums
    logic signed [63:0] kf_est = '0;
    logic        [63:0] kf_var = '0;
    bit                 kf_started = 1'b0;

    t_est_beat pending_est_q[$];

    int  n_mismatch = 0;
    int  n_samples = 0;
    int  n_results = 0;
    int  n_settings = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    int  hold_request = 0;

    // ------------------------------------------------------------------
    // filter predictor
    // ------------------------------------------------------------------

    function automatic logic [127:0] magnitude128(input logic signed [63:0] v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return {64'd0, m};
    endfunction

    // x += velocity*time_step (magnitude rounded, ties away), P += Q, both saturated
    function automatic void predict_state();
        logic [127:0]       prod;
        logic [127:0]       delta;
        logic signed [63:0] step;
        logic signed [63:0] sum;
        logic [63:0]        p;
        prod = (magnitude128(64'(r_velocity)) * {96'd0, r_time_step}
                + (128'd1 << (FB - 1))) >> FB;
        delta = (prod > (128'd1 << DW)) ? (128'd1 << DW) : prod;
        step = delta[63:0];
        sum = (r_velocity < 0) ? kf_est - step : kf_est + step;
        if (sum > EST_MAX) sum = EST_MAX;
        if (sum < EST_MIN) sum = EST_MIN;
        kf_est = sum;
        p = kf_var + {32'd0, r_model_var};
        kf_var = (p > VAR_MAX) ? VAR_MAX : p;
    endfunction

    // weighted average of prior and sample, rounded to nearest; variance becomes P*R/(P+R)
    function automatic void update_state(input logic signed [DW-1:0] z);
        logic [127:0] pw;
        logic [127:0] rw;
        logic [127:0] den;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] pv;
        bit           neg;
        pw = {64'd0, kf_var};
        rw = {96'd0, r_meas_var};
        den = pw + rw;
        // zero denominator: keep the prior estimate, variance drops to zero
        if (den == 0) begin
            kf_var = '0;
            return;
        end
        a = pw * magnitude128(64'(z));
        b = rw * magnitude128(kf_est);
        if ((z < 0) == (kf_est < 0)) begin
            num = a + b;
            neg = (z < 0);
        end else if (a >= b) begin
            num = a - b;
            neg = (z < 0);
        end else begin
            num = b - a;
            neg = (kf_est < 0);
        end
        quo = (num + (den >> 1)) / den;
        kf_est = neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
        pv = (pw * rw + (den >> 1)) / den;
        kf_var = pv[63:0];
    endfunction

    function automatic t_est_beat filter_step(input logic signed [DW-1:0] z);
        t_est_beat res;
        // first sample after reset starts from the initial registers, no predict
        if (!kf_started) begin
            kf_est = 64'(r_init_est);
            kf_var = {32'd0, r_init_var};
            kf_started = 1'b1;
        end else begin
            predict_state();
        end
        update_state(z);
        res.estimate = kf_est[DW-1:0];
        res.variance = kf_var[DW-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        case (idx)
            CFG_MEAS_VAR:  r_meas_var  = value;
            CFG_MODEL_VAR: r_model_var = value;
            CFG_VELOCITY:  r_velocity  = value;
            CFG_TIME_STEP: r_time_step = value;
            CFG_INIT_EST:  r_init_est  = value;
            CFG_INIT_VAR:  r_init_var  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // offer one sample and wait for its beat; the predictor runs on acceptance
    task automatic send_sample(input logic signed [DW-1:0] z);
        int gap;
        int mode;
        mode = idle_on ? $urandom_range(0, 9) : 9;
        if (mode <= 1) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            meas_ch.valid = 1'b0;
            // second flavor: let the gap start as the block turns ready
            if (mode == 1) begin
                do @(posedge i_clk); while (!meas_ch.ready);
            end
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        meas_ch.valid       = 1'b1;
        meas_ch.measurement = z;
        do @(posedge i_clk); while (!meas_ch.ready);
        pending_est_q.push_back(filter_step(z));
        n_samples++;
    endtask

    // sender pause: nothing offered until every result beat is back
    task automatic wait_drained();
        @(negedge i_clk);
        meas_ch.valid = 1'b0;
        while (pending_est_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_unsigned();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            3, 4, 5: return $urandom_range(1 << 12, 1 << 20);
            6, 7:    return $urandom_range(1 << 16, 1 << 24);
            8:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_velocity();
        case ($urandom_range(0, 9))
            0:             return 32'h8000_0000;
            1:             return 32'h7FFF_FFFF;
            2:             return '0;
            3, 4, 5, 6, 7: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
            default:       return $urandom;
        endcase
    endfunction

    // mostly samples near the current estimate so the filter tracks, some wild
    function automatic logic signed [DW-1:0] pick_measurement();
        int off;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1, 2, 3: return $urandom;
            default: begin
                off = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                return kf_est[DW-1:0] + off;
            end
        endcase
    endfunction

    task automatic randomize_settings();
        write_reg(CFG_MEAS_VAR, pick_unsigned());
        write_reg(CFG_MODEL_VAR, pick_unsigned());
        write_reg(CFG_VELOCITY, pick_velocity());
        write_reg(CFG_TIME_STEP, pick_unsigned());
        // initial registers no longer matter once started, sometimes written anyway
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_INIT_EST, $urandom);
            write_reg(CFG_INIT_VAR, $urandom);
        end
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first sample: only the update, from the extreme initial state
    task automatic test_first_sample();
        write_reg(CFG_INIT_EST, 32'h8000_0000);
        write_reg(CFG_INIT_VAR, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
    endtask

    // remaining registers still at their reset values
    task automatic test_reset_settings();
        send_sample(32'h0000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
    endtask

    // half-lsb predict steps round away from zero in both directions
    task automatic test_rounding_ties();
        wait_drained();
        write_reg(CFG_MEAS_VAR, 32'd1);
        write_reg(CFG_MODEL_VAR, '0);
        write_reg(CFG_VELOCITY, 32'hFFFF_FFFF);
        write_reg(CFG_TIME_STEP, 32'h0000_8000);
        send_sample(32'h0000_0000);
        wait_drained();
        write_reg(CFG_VELOCITY, 32'd1);
        send_sample(32'h0000_0000);
        wait_drained();
        write_reg(CFG_VELOCITY, 32'd3);
        send_sample(32'h0000_0001);
    endtask

    // predict step overflows the estimate range both ways
    task automatic test_predict_saturation();
        wait_drained();
        write_reg(CFG_MEAS_VAR, 32'hFFFF_FFFF);
        write_reg(CFG_VELOCITY, 32'h7FFF_FFFF);
        write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        wait_drained();
        write_reg(CFG_VELOCITY, 32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
    endtask

    // P + Q clips at the unsigned maximum
    task automatic test_variance_saturation();
        wait_drained();
        write_reg(CFG_MODEL_VAR, 32'hFFFF_FFFF);
        write_reg(CFG_VELOCITY, '0);
        send_sample($urandom);
        send_sample($urandom);
    endtask

    // R and Q both zero: variance collapses, then P + R is zero
    task automatic test_zero_denominator();
        wait_drained();
        write_reg(CFG_MEAS_VAR, '0);
        write_reg(CFG_MODEL_VAR, '0);
        write_reg(CFG_VELOCITY, 32'h0001_0000);
        write_reg(CFG_TIME_STEP, 32'h0001_0000);
        send_sample($urandom);
        send_sample($urandom);
        send_sample($urandom);
    endtask

    // writes past the register list must leave the settings alone
    task automatic test_spare_indexes();
        wait_drained();
        write_reg(CFG_MEAS_VAR, 32'h0001_0000);
        write_reg(CFG_MODEL_VAR, 32'h0001_0000);
        write_reg(CFG_VELOCITY, '0);
        write_reg(CFG_IDX_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_SPARE_B, $urandom);
        send_sample(pick_measurement());
        send_sample(pick_measurement());
    endtask

    // receiver holds off for a long stretch while samples keep coming,
    // so a result parks in the output register and the input stalls
    task automatic test_output_stall();
        wait_drained();
        hold_request = 400;
        repeat (6) send_sample(pick_measurement());
        wait_drained();
    endtask

    task automatic test_random_sweep(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            wait_drained();
            randomize_settings();
            repeat (per_phase) send_sample(pick_measurement());
        end
    endtask

    // last stretch with both sides at full rate
    task automatic test_quiet_tail(input int count);
        wait_drained();
        idle_on = 1'b0;
        randomize_settings();
        repeat (count) send_sample(pick_measurement());
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stall bursts, plus the long hold when requested
    initial begin : result_receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        est_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                est_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                est_ch.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                est_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                est_ch.ready = 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [DW-1:0] want,
                                 input logic [DW-1:0] got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // each result beat against the oldest pending expectation
    always @(posedge i_clk) begin : result_check
        t_est_beat want;
        if (i_rst_n && est_ch.valid && est_ch.ready) begin
            n_results++;
            if (pending_est_q.size() == 0) begin
                note_mismatch("unexpected result beat", '0, est_ch.estimate);
            end else begin
                want = pending_est_q.pop_front();
                if (est_ch.estimate !== want.estimate)
                    note_mismatch("estimate", want.estimate, est_ch.estimate);
                if (est_ch.estimate_variance !== want.variance)
                    note_mismatch("estimate_variance", want.variance,
                                  est_ch.estimate_variance);
            end
        end
    end

    // watchdog: too long without a beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (meas_ch.valid && meas_ch.ready) || (est_ch.valid && est_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, pending_est_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_MEAS_VAR;
        i_cfg_data          = '0;
        meas_ch.valid       = 1'b0;
        meas_ch.measurement = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_sample();
        test_reset_settings();
        test_rounding_ties();
        test_predict_saturation();
        test_variance_saturation();
        test_zero_denominator();
        test_spare_indexes();
        test_output_stall();
        test_random_sweep(11, 100);
        test_quiet_tail(150);

        // all beats in, then let the pipeline settle before the final check
        wait_drained();
        repeat (FINAL_SETTLE) @(posedge i_clk);
        if (pending_est_q.size() != 0)
            note_mismatch("results never delivered", '0, pending_est_q.size());

        $display("covered %0d samples over %0d random filter settings plus directed corners",
                 n_samples, n_settings);
        $display("%0d result beats compared, %0d mismatches", n_results, n_mismatch);
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/skf_pkg.sv
rtl/skf_meas_if.sv
rtl/skf_est_if.sv
rtl/skf_mul.sv
rtl/skf_div.sv
rtl/scalar_kalman_filter.sv
verif/scalar_kalman_filter_tb.sv
